// ===== rtl/core/cct_pkg.sv =====
// Package for the contour circularity test: widths, reset values, register
// indexes and the structs shared by the sequencer, the top level and the testbench.
// No dependencies.
package cct_pkg;

    localparam int MAX_POINTS = 1024;

    localparam int PT_W       = 12;                      // point coordinate, pixels
    localparam int CEN_W      = 16;                      // centroid, Q12.4
    localparam int FRAC_W     = 4;                       // fraction bits of a distance
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);  // point counter
    localparam int ROOT_W     = 17;                      // bits of one distance
    localparam int DIST_W     = 18;                      // stored distance width
    localparam int RAD_W      = 34;                      // radicand / shift source
    localparam int SUM_W      = 28;                      // distance sum
    localparam int DIV_W      = SUM_W + 1;               // rounded dividend, quotient
    localparam int MEAN_W     = 17;
    localparam int REM_W      = 19;                      // partial remainder
    localparam int STEP_W     = REM_W + 2;               // compare-subtract width
    localparam int ITER_W     = $clog2(DIV_W);           // iteration counter
    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int RADIUS_W   = 13;
    localparam int THR_W      = 12;
    localparam int THR_FRAC_W = 8;                       // Q4.8 threshold
    localparam int RATIO_ONE  = 256;                     // 1.0 in Q4.8
    localparam int CFG_W      = 13;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    localparam logic [SUM_W-1:0]    SUM_MAX     = '1;
    localparam logic [DIST_W-1:0]   SMALL_RESET = '1;
    localparam logic [RADIUS_W-1:0] MIN_RADIUS_RESET = 13'd160;
    localparam logic [RADIUS_W-1:0] MAX_RADIUS_RESET = 13'd1600;
    localparam logic [THR_W-1:0]    RATIO_THR_RESET  = 12'd51;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MIN_RADIUS = 2'd0,
        REG_MAX_RADIUS = 2'd1,
        REG_RATIO_THR  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] min_radius;
        logic [RADIUS_W-1:0] max_radius;
        logic [THR_W-1:0]    ratio_threshold;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]  point_count;
        logic [MEAN_W-1:0] mean_radius;
        logic              is_circle;
    } result_t;

endpackage

// ===== rtl/core/contour_circularity_test.sv =====
// Top level of the contour circularity test: configuration registers, output
// register, and the sequencer with its shared multiplier and step unit.
// Depends on cct_pkg, cct_mul, cct_step, cct_seq.
//
// Takes the points of one contour, one transfer per point with the contour
// centroid alongside, and on the point marked by s_tlast sends one result
// transfer: the circle verdict, the rounded mean distance (Q13.4) and the
// point count. Each point goes through the shared multiplier to square and
// add the offsets, the shared compare-subtract unit for the square root (one
// root bit per step), the radius and ratio checks, each ratio check taking
// one more multiplier pass, and a closing step before the block is ready
// again. Points arriving after a rejection go straight to the closing step.
// The last point of a kept contour adds a restoring divide on the same
// compare-subtract unit, then hands the result to the output register.
// s_tready is high only while the sequencer is idle; a result waits in the
// output register, and the sequencer takes the next point while it waits,
// stalling only when a second result would overwrite it. Configuration writes
// are taken on any cycle but belong between contours.
module contour_circularity_test
    import cct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input points
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // point_x, point_y, centroid_x, centroid_y
    input  logic                   s_tlast,   // last_point
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // is_circle, mean_radius, point_count, zero fill
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    cfg_t                  cfg_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_data_reg;

    logic                  res_valid;
    logic                  res_ready;
    result_t               res;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [STEP_W-1:0]     step_a;
    logic [STEP_W-1:0]     step_b;
    logic                  step_ge;
    logic [STEP_W-1:0]     step_diff;

    // Configuration: an index beyond the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_radius      <= MIN_RADIUS_RESET;
            cfg_reg.max_radius      <= MAX_RADIUS_RESET;
            cfg_reg.ratio_threshold <= RATIO_THR_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_MIN_RADIUS: cfg_reg.min_radius      <= cfg_wdata[RADIUS_W-1:0];
                REG_MAX_RADIUS: cfg_reg.max_radius      <= cfg_wdata[RADIUS_W-1:0];
                REG_RATIO_THR:  cfg_reg.ratio_threshold <= cfg_wdata[THR_W-1:0];
                default:        cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Output register: load when empty or when the waiting result transfers.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

    cct_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_px     (s_tdata[PT_W-1:0]),
        .in_py     (s_tdata[2*PT_W-1:PT_W]),
        .in_cx     (s_tdata[2*PT_W+CEN_W-1:2*PT_W]),
        .in_cy     (s_tdata[2*PT_W+2*CEN_W-1:2*PT_W+CEN_W]),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_p     (mul_p),
        .step_a    (step_a),
        .step_b    (step_b),
        .step_ge   (step_ge),
        .step_diff (step_diff)
    );

    cct_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    cct_step u_step (
        .a    (step_a),
        .b    (step_b),
        .ge   (step_ge),
        .diff (step_diff)
    );

endmodule

// ===== rtl/core/cct_mul.sv =====
// Shared registered multiplier of the contour circularity test.
// Depends on cct_pkg.
module cct_mul
    import cct_pkg::*;
(
    input  logic               clk,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [PROD_W-1:0]  p
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = prod_reg;

endmodule

// ===== rtl/core/cct_step.sv =====
// Shared compare-subtract step for the digit-by-digit square root and the
// restoring division. Depends on cct_pkg.
module cct_step
    import cct_pkg::*;
(
    input  logic [STEP_W-1:0] a,
    input  logic [STEP_W-1:0] b,
    output logic              ge,
    output logic [STEP_W-1:0] diff
);

    // take the subtraction only when the trial value fits
    assign ge   = (a >= b);
    assign diff = a - b;

endmodule

// ===== rtl/core/cct_seq.sv =====
// Sequencer and per-contour state of the contour circularity test: squares,
// square root, range and ratio checks, mean division. Depends on cct_pkg.
module cct_seq
    import cct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PT_W-1:0]    in_px,
    input  logic [PT_W-1:0]    in_py,
    input  logic [CEN_W-1:0]   in_cx,
    input  logic [CEN_W-1:0]   in_cy,
    input  logic               in_last,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output logic [MUL_A_W-1:0] mul_a,
    output logic [MUL_B_W-1:0] mul_b,
    input  logic [PROD_W-1:0]  mul_p,
    output logic [STEP_W-1:0]  step_a,
    output logic [STEP_W-1:0]  step_b,
    input  logic               step_ge,
    input  logic [STEP_W-1:0]  step_diff
);

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_SQX     = 12'b0000_0000_0010,
        ST_SQY     = 12'b0000_0000_0100,
        ST_ADD     = 12'b0000_0000_1000,
        ST_ROOT    = 12'b0000_0001_0000,
        ST_UPD_MAX = 12'b0000_0010_0000,
        ST_RAT_MAX = 12'b0000_0100_0000,
        ST_UPD_MIN = 12'b0000_1000_0000,
        ST_RAT_MIN = 12'b0001_0000_0000,
        ST_FIN     = 12'b0010_0000_0000,
        ST_DIV     = 12'b0100_0000_0000,
        ST_OUT     = 12'b1000_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [DIST_W-1:0]   small_reg, small_next;
    logic [DIST_W-1:0]   large_reg, large_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    points_reg, points_next;
    logic                rejected_reg, rejected_next;
    logic [CEN_W-1:0]    dx_reg, dx_next;
    logic [CEN_W-1:0]    dy_reg, dy_next;
    logic                last_reg, last_next;
    logic [RAD_W-1:0]    src_reg, src_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    acc_reg, acc_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;

    logic [CEN_W-1:0]    px_q, py_q;
    logic [DIST_W-1:0]   pt_dist;
    logic [SUM_W:0]      sum_wide;
    logic [DIV_W-1:0]    dividend;
    logic [MUL_B_W-1:0]  ratio_scale;
    logic [PROD_W-1:0]   large_scaled;

    assign px_q         = {in_px, FRAC_W'(0)};
    assign py_q         = {in_py, FRAC_W'(0)};
    assign pt_dist      = DIST_W'(acc_reg[ROOT_W-1:0]);
    assign sum_wide     = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(pt_dist);
    assign dividend     = DIV_W'(sum_reg) + DIV_W'(points_reg >> 1);
    assign ratio_scale  = MUL_B_W'(cfg.ratio_threshold) + MUL_B_W'(RATIO_ONE);
    assign large_scaled = PROD_W'({large_reg, THR_FRAC_W'(0)});

    assign res.is_circle   = !rejected_reg;
    assign res.mean_radius = acc_reg[MEAN_W-1:0];
    assign res.point_count = points_reg;

    always_comb
    begin
        state_next    = state_reg;
        small_next    = small_reg;
        large_next    = large_reg;
        sum_next      = sum_reg;
        points_next   = points_reg;
        rejected_next = rejected_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        last_next     = last_reg;
        src_next      = src_reg;
        rem_next      = rem_reg;
        acc_next      = acc_reg;
        iter_next     = iter_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        step_a        = '0;
        step_b        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dx_next   = (px_q >= in_cx) ? px_q - in_cx : in_cx - px_q;
                    dy_next   = (py_q >= in_cy) ? py_q - in_cy : in_cy - py_q;
                    last_next = in_last;
                    if (rejected_reg)
                    begin
                        // rejected contour: only count the point
                        if (points_reg < CNT_W'(MAX_POINTS))
                        begin
                            points_next = points_reg + 1'b1;
                        end
                        state_next = ST_FIN;
                    end
                    else if (points_reg >= CNT_W'(MAX_POINTS))
                    begin
                        rejected_next = 1'b1;
                        state_next    = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SQX;
                    end
                end
            end
            ST_SQX:
            begin
                mul_a      = MUL_A_W'(dx_reg);
                mul_b      = dx_reg;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                mul_a      = MUL_A_W'(dy_reg);
                mul_b      = dy_reg;
                src_next   = RAD_W'(mul_p);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                src_next   = src_reg + RAD_W'(mul_p);
                rem_next   = '0;
                acc_next   = '0;
                iter_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                // one root bit per cycle, two radicand bits shifted in
                step_a    = {rem_reg, src_reg[RAD_W-1 -: 2]};
                step_b    = STEP_W'({acc_reg[ROOT_W-1:0], 2'b01});
                rem_next  = step_ge ? step_diff[REM_W-1:0] : step_a[REM_W-1:0];
                src_next  = src_reg << 2;
                acc_next  = {acc_reg[DIV_W-2:0], step_ge};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(ROOT_W - 1))
                begin
                    state_next = ST_UPD_MAX;
                end
            end
            ST_UPD_MAX:
            begin
                points_next = points_reg + 1'b1;
                sum_next    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                if (pt_dist > large_reg)
                begin
                    large_next = pt_dist;
                    if (pt_dist > DIST_W'(cfg.max_radius))
                    begin
                        rejected_next = 1'b1;
                        state_next    = ST_FIN;
                    end
                    else
                    begin
                        mul_a      = small_reg;
                        mul_b      = ratio_scale;
                        state_next = ST_RAT_MAX;
                    end
                end
                else
                begin
                    state_next = ST_UPD_MIN;
                end
            end
            ST_RAT_MAX:
            begin
                if ((small_reg != '0) && (large_scaled > mul_p))
                begin
                    rejected_next = 1'b1;
                    state_next    = ST_FIN;
                end
                else
                begin
                    state_next = ST_UPD_MIN;
                end
            end
            ST_UPD_MIN:
            begin
                if (pt_dist < small_reg)
                begin
                    small_next = pt_dist;
                    if (pt_dist < DIST_W'(cfg.min_radius))
                    begin
                        rejected_next = 1'b1;
                        state_next    = ST_FIN;
                    end
                    else
                    begin
                        mul_a      = pt_dist;
                        mul_b      = ratio_scale;
                        state_next = ST_RAT_MIN;
                    end
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RAT_MIN:
            begin
                if ((small_reg != '0) && (large_scaled > mul_p))
                begin
                    rejected_next = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!rejected_reg && (points_reg != '0))
                begin
                    src_next   = {dividend, (RAD_W-DIV_W)'(0)};
                    rem_next   = '0;
                    acc_next   = '0;
                    iter_next  = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    acc_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                step_a    = STEP_W'({rem_reg[CNT_W:0], src_reg[RAD_W-1]});
                step_b    = STEP_W'(points_reg);
                rem_next  = step_ge ? step_diff[REM_W-1:0] : step_a[REM_W-1:0];
                src_next  = src_reg << 1;
                acc_next  = {acc_reg[DIV_W-2:0], step_ge};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(DIV_W - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    small_next    = SMALL_RESET;
                    large_next    = '0;
                    sum_next      = '0;
                    points_next   = '0;
                    rejected_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            small_reg    <= SMALL_RESET;
            large_reg    <= '0;
            sum_reg      <= '0;
            points_reg   <= '0;
            rejected_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            small_reg    <= small_next;
            large_reg    <= large_next;
            sum_reg      <= sum_next;
            points_reg   <= points_next;
            rejected_reg <= rejected_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        last_reg <= last_next;
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        iter_reg <= iter_next;
    end

endmodule

// ===== rtl/core/cct_checker.sv =====
// Port-level checker for the contour circularity test, bound to the top level.
// Depends on cct_pkg and contour_circularity_test.
module cct_checker
    import cct_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a waiting result holds until it transfers
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every point leaves the block busy in the cycle after its transfer
    a_busy_after_point: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after a point transfer");

    // a rejected contour reports a zero mean
    a_reject_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[MEAN_W:1] == '0)
        else $error("rejected contour with nonzero mean");

    // a kept contour has at least one point and never more than the limit
    a_circle_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |->
            (m_tdata[MEAN_W+CNT_W:MEAN_W+1] != '0) &&
            (m_tdata[MEAN_W+CNT_W:MEAN_W+1] <= CNT_W'(MAX_POINTS)))
        else $error("kept contour with bad point count");

endmodule

bind contour_circularity_test cct_checker u_cct_checker (.*);

// ===== test/tb.sv =====
// Testbench for contour_circularity_test: point transfers in, verdict transfers out.
// Predicts each verdict from its own model of the distance, radius and ratio checks.
// Depends on cct_pkg and the contour_circularity_test RTL.
`timescale 1ns / 1ps

module tb;
    import cct_pkg::*;

    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int SETTLE_CYCLES     = 64;      // longer than one point plus the divide
    localparam int LONG_STALL_CYCLES = 600;
    localparam int PRINT_CAP         = 100;
    localparam logic [CEN_W-1:0] CEN = 16'd16000;   // 1000 pixels in Q12.4
    // index past the register list; writes to it must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // point_x, point_y, centroid_x, centroid_y
    logic                   s_tlast;    // last_point
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // is_circle, mean_radius, point_count, zero fill
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;

    // Predicted contour state and register copy
    cfg_t              cur_cfg = '{min_radius: MIN_RADIUS_RESET,
                                   max_radius: MAX_RADIUS_RESET,
                                   ratio_threshold: RATIO_THR_RESET};
    logic [DIST_W-1:0] near_dist  = SMALL_RESET;
    logic [DIST_W-1:0] far_dist   = '0;
    logic [SUM_W-1:0]  dist_total = '0;
    int                pts_seen   = 0;
    bit                contour_bad = 1'b0;

    result_t verdicts_due[$];   // verdicts still owed by the block, oldest first

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  items_taken   = 0;
    int  mismatches    = 0;
    int  cycle_count   = 0;
    bit  hold_active   = 1'b0;
    event long_stall_ev;

    contour_circularity_test DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run; the budget is many times the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Result side: random backpressure, forced low while a long hold is active.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long hold-off, counted on falling edges so the ready driver never races it.
    initial
    begin
        forever
        begin
            @(long_stall_ev);
            @(negedge clk);
            hold_active = 1'b1;
            repeat (LONG_STALL_CYCLES) @(negedge clk);
            hold_active = 1'b0;
        end
    end

    // Print one line per mismatch (up to a cap) and count all of them.
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("tb: %0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        // build the root from the top bit down, keeping each bit whose square still fits
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // max/min - 1 above threshold, in Q4.8; skipped while the smallest distance is zero
    function automatic bit ratio_broken();
        longint unsigned lhs;
        longint unsigned rhs;
        if (near_dist == 0)
            return 1'b0;
        lhs = longint'(far_dist) * RATIO_ONE;
        rhs = longint'(near_dist) * (RATIO_ONE + longint'(cur_cfg.ratio_threshold));
        return lhs > rhs;
    endfunction

    // Advance the predicted contour state by one accepted point; queue a verdict on the last.
    task automatic score_point(input logic [PT_W-1:0] px, input logic [PT_W-1:0] py,
                               input logic [CEN_W-1:0] cx, input logic [CEN_W-1:0] cy,
                               input bit last);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned pt_dist;
        longint unsigned total;
        longint unsigned mean;
        result_t verdict;
        ax = 64'({px, 4'b0000});
        ay = 64'({py, 4'b0000});
        if (contour_bad)
        begin
            // rejected contours only count their points
            if (pts_seen < MAX_POINTS)
                pts_seen++;
        end
        else if (pts_seen >= MAX_POINTS)
            contour_bad = 1'b1;
        else
        begin
            dx = (ax >= cx) ? ax - cx : cx - ax;
            dy = (ay >= cy) ? ay - cy : cy - ay;
            pt_dist = floor_sqrt(dx * dx + dy * dy);
            pts_seen++;
            total = dist_total + pt_dist;
            dist_total = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
            // largest check first, then smallest, on the same point
            if (pt_dist > far_dist)
            begin
                far_dist = pt_dist[DIST_W-1:0];
                if (pt_dist > cur_cfg.max_radius || ratio_broken())
                    contour_bad = 1'b1;
            end
            if (!contour_bad && pt_dist < near_dist)
            begin
                near_dist = pt_dist[DIST_W-1:0];
                if (pt_dist < cur_cfg.min_radius || ratio_broken())
                    contour_bad = 1'b1;
            end
        end
        if (last)
        begin
            mean = 0;
            if (!contour_bad && pts_seen != 0)
                mean = (longint'(dist_total) + pts_seen / 2) / pts_seen;
            verdict.is_circle   = !contour_bad;
            verdict.mean_radius = mean[MEAN_W-1:0];
            verdict.point_count = pts_seen[CNT_W-1:0];
            verdicts_due.push_back(verdict);
            near_dist   = SMALL_RESET;
            far_dist    = '0;
            dist_total  = '0;
            pts_seen    = 0;
            contour_bad = 1'b0;
        end
    endtask

    // Offer one point, hold it until the transfer, then score it.
    task automatic send_point(input int x, input int y, input logic [CEN_W-1:0] cx,
                              input logic [CEN_W-1:0] cy, input bit last);
        logic [PT_W-1:0] px;
        logic [PT_W-1:0] py;
        px = x[PT_W-1:0];
        py = y[PT_W-1:0];
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cy, cx, py, px};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_taken++;
        score_point(px, py, cx, cy, last);
    endtask

    // Points on a circle of radius r pixels around a random centroid, with +-j pixels noise.
    task automatic send_ring(input int npts, input int r, input int j);
        int cpx;
        int cpy;
        int dx;
        int dy;
        logic [CEN_W-1:0] cx;
        logic [CEN_W-1:0] cy;
        cpx = $urandom_range(4094 - r - j, r + j + 1);
        cpy = $urandom_range(4094 - r - j, r + j + 1);
        cx = CEN_W'(cpx * 16 + $urandom_range(15));
        cy = CEN_W'(cpy * 16 + $urandom_range(15));
        for (int i = 0; i < npts; i++)
        begin
            dx = int'($urandom_range(2 * r)) - r;
            dy = int'(floor_sqrt(longint'(r * r - dx * dx)));
            if ($urandom_range(1))
                dy = -dy;
            dx += int'($urandom_range(2 * j)) - j;
            dy += int'($urandom_range(2 * j)) - j;
            send_point(cpx + dx, cpy + dy, cx, cy, i == npts - 1);
        end
    endtask

    // Unrelated points and centroid: mostly rejects, covers every field bit.
    task automatic send_scatter(input int npts);
        logic [CEN_W-1:0] cx;
        logic [CEN_W-1:0] cy;
        cx = CEN_W'($urandom);
        cy = CEN_W'($urandom);
        for (int i = 0; i < npts; i++)
            send_point($urandom_range(4095), $urandom_range(4095), cx, cy, i == npts - 1);
    endtask

    // Drop valid, wait for every owed verdict, then let the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers plus the spare index; only while idle.
    task automatic program_regs(input logic [CFG_W-1:0] lo_lim, input logic [CFG_W-1:0] hi_lim,
                                input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] junk);
        logic [CFG_ADDR_W-1:0] idx[4];
        logic [CFG_W-1:0]      val[4];
        idx = '{REG_MIN_RADIUS, REG_MAX_RADIUS, REG_RATIO_THR, REG_SPARE};
        val = '{lo_lim, hi_lim, thr, junk};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            case (idx[i])
                REG_MIN_RADIUS: cur_cfg.min_radius      = val[i];
                REG_MAX_RADIUS: cur_cfg.max_radius      = val[i];
                REG_RATIO_THR:  cur_cfg.ratio_threshold = val[i][THR_W-1:0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Boundaries of the default checks, rejection behavior and field extremes.
    task automatic test_directed_checks();
        send_idle_pct = 9;
        recv_idle_pct = 59;
        send_point(1100, 1000, CEN, CEN, 1);     // exactly max radius: kept
        send_point(1101, 1000, CEN, CEN, 1);     // just past max radius
        send_point(1000, 1010, CEN, CEN, 1);     // exactly min radius: kept
        send_point(1000, 991, CEN, CEN, 1);      // just under min radius
        send_point(1050, 1000, CEN, CEN, 0);     // ratio just over threshold
        send_point(1000, 1060, CEN, CEN, 1);
        send_point(1050, 1000, CEN, CEN, 0);     // ratio just under threshold
        send_point(1000, 941, CEN, CEN, 1);
        send_point(1000, 1100, CEN, CEN, 0);     // largest set first, then smallest fails
        send_point(1009, 1000, CEN, CEN, 1);
        send_point(1200, 1000, CEN, CEN, 0);     // early reject, later points only counted
        send_point(1050, 1000, CEN, CEN, 0);
        send_point(1050, 1000, CEN, CEN, 1);
        send_point(1000, 1000, CEN, CEN, 1);     // zero distance under default min
        send_point(4095, 4095, 16'h0000, 16'h0000, 1);
        send_point(0, 0, 16'hFFFF, 16'hFFFF, 1);
        send_point(4095, 0, 16'h0000, 16'hFFFF, 1);
    endtask

    // Widest and narrowest register settings, a dropped spare write, a masked threshold.
    task automatic test_register_extremes();
        wait_idle();
        program_regs(13'd0, 13'd8191, 13'd4095, 13'd8191);
        send_point(1000, 1000, CEN, CEN, 1);     // zero distance now kept
        send_point(1000, 1000, CEN, CEN, 0);     // zero smallest: ratio check skipped
        send_point(1100, 1000, CEN, CEN, 1);
        send_point(0, 0, 16'hFFFF, 16'hFFFF, 1); // beyond the largest max radius
        wait_idle();
        program_regs(13'd8191, 13'd0, 13'h1000, 13'd0);  // threshold bit 12 dropped
        send_point(1000, 1000, CEN, CEN, 1);
        send_point(1001, 1000, CEN, CEN, 1);
        wait_idle();
        program_regs(MIN_RADIUS_RESET, MAX_RADIUS_RESET, RATIO_THR_RESET, 13'd0);
    endtask

    // Mostly well-formed rings with random content, some noisy rings and scatter.
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int quota);
        int goal;
        int kind;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        goal = items_taken + quota;
        while (items_taken < goal)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
                send_ring($urandom_range(16, 1), $urandom_range(140, 6), $urandom_range(1));
            else if (kind < 85)
                send_ring($urandom_range(4, 1), $urandom_range(400), $urandom_range(3));
            else
                send_scatter($urandom_range(6, 1));
        end
    endtask

    // Hold the result side while points keep coming, so the input stalls; then pause and send more rings.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> long_stall_ev;
        repeat (24) send_ring(1, 50, 0);
        wait_idle();
        repeat (6) send_ring($urandom_range(5, 1), 60, 1);
    endtask

    // Compare each result transfer with the oldest owed verdict.
    always @(posedge clk)
    begin : watch_results
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdicts_due.size() == 0)
                report_mismatch("unexpected result", 32'd0, m_tdata);
            else
            begin
                want = verdicts_due.pop_front();
                if (m_tdata[0] !== want.is_circle)
                    report_mismatch("is_circle", 32'(want.is_circle), 32'(m_tdata[0]));
                if (m_tdata[MEAN_W:1] !== want.mean_radius)
                    report_mismatch("mean_radius", 32'(want.mean_radius),
                                    32'(m_tdata[MEAN_W:1]));
                if (m_tdata[MEAN_W+CNT_W:MEAN_W+1] !== want.point_count)
                    report_mismatch("point_count", 32'(want.point_count),
                                    32'(m_tdata[MEAN_W+CNT_W:MEAN_W+1]));
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_MIN_RADIUS;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_checks();
        test_register_extremes();

        wait_idle();
        program_regs(MIN_RADIUS_RESET, MAX_RADIUS_RESET, RATIO_THR_RESET, 13'($urandom));
        test_random_traffic(9, 59, 230);

        wait_idle();
        program_regs(13'($urandom_range(600)), 13'($urandom_range(8191, 1200)),
                     13'($urandom_range(4095)), 13'($urandom));
        test_random_traffic(59, 9, 230);

        wait_idle();
        program_regs(13'($urandom_range(200)), 13'($urandom_range(2400, 1400)),
                     13'($urandom_range(120, 20)), 13'($urandom));
        test_random_traffic(0, 0, 240);

        test_backpressure();

        // drain: every verdict in, then a settle window
        wait_idle();
        foreach (verdicts_due[i])
            report_mismatch("missing result", 32'(verdicts_due[i]), 32'd0);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
